[design/point_pair_match_score_top_defines.svh]
// Assertion macros shared by the point pair match score design.
`ifndef POINT_PAIR_MATCH_SCORE_TOP_DEFINES_SVH
`define POINT_PAIR_MATCH_SCORE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside of reset.
`define PPMS_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("point pair match score check failed");
// Check a property on every clock edge, reset included.
`define PPMS_ASSERT(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("point pair match score check failed");
`else
`define PPMS_ASSERT_RST(label, clk, rst_n, prop)
`define PPMS_ASSERT(label, clk, prop)
`endif
`endif

[design/ppms_pkg.sv]
// Shared widths, constants and tables of the point pair match score design.
package ppms_pkg;

  // Field widths.
  localparam int COORD_W    = 24;
  localparam int FRAC_W     = 8;
  localparam int HEAD_W     = 17;
  localparam int DIST_W     = 25;
  localparam int OPP_W      = 16;
  localparam int AZD_W      = 17;
  localparam int SCORE_W    = 25;
  localparam int WGT_W      = 16;
  localparam int THR_W      = 25;
  localparam int REL_W      = 3;
  localparam int METRICS    = 4;
  localparam int MAG_W      = COORD_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int REL_REG_W  = REL_W * METRICS;
  localparam int WGT_REG_W  = WGT_W * METRICS;

  localparam logic [CFG_IDX_W-1:0] REG_RELATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_AZ   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_HEAD = 3'd5;

  // Relation codes.
  localparam logic [REL_W-1:0] REL_NONE    = 3'd0;
  localparam logic [REL_W-1:0] REL_GREATER = 3'd1;
  localparam logic [REL_W-1:0] REL_LESS    = 3'd2;
  localparam logic [REL_W-1:0] REL_EQUAL   = 3'd3;
  localparam logic [REL_W-1:0] REL_UNEQUAL = 3'd4;

  // Angles in degrees with FRAC_W fraction bits.
  localparam int DEG_HALF  = 180 << FRAC_W;
  localparam int DEG_RIGHT = 90 << FRAC_W;

  // Arctangent pipeline.
  localparam int CORDIC_STEPS = 31;
  localparam int ANG_FRAC     = 24;
  localparam int CORDIC_SHIFT = 59 - COORD_W;
  localparam int CV_W         = 62;
  localparam int Z_W          = 32;
  localparam int K_W          = 15;
  localparam int ATAN_W       = 30;

  // Arctangent of 2^-i in degrees with ANG_FRAC fraction bits.
  localparam logic [ATAN_W-1:0] ATAN_DEG_Q24 [CORDIC_STEPS] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
    30'd30029717,  30'd15018523,  30'd7509720,   30'd3754917,   30'd1877466,
    30'd938734,    30'd469367,    30'd234684,    30'd117342,    30'd58671,
    30'd29335,     30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115,       30'd57,
    30'd29,        30'd14,        30'd7,         30'd4,         30'd2,
    30'd1
  };

endpackage

[design/ppms_isqrt.sv]
// Pipelined distance unit: squares, sum and a restoring square root, one bit per stage.
module ppms_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ppms_pkg::MAG_W-1:0]    a,
  input  logic [ppms_pkg::MAG_W-1:0]    b,
  output logic [ppms_pkg::DIST_W-1:0]   root
);
  import ppms_pkg::*;

  localparam int STEPS = DIST_W;
  localparam int RAD_W = 2 * STEPS;
  localparam int REM_W = STEPS + 1;
  localparam int WRK_W = STEPS + 3;

  logic [2*MAG_W-1:0] sqa_r;
  logic [2*MAG_W-1:0] sqb_r;
  logic [RAD_W-1:0]   rad_r  [STEPS];
  logic [REM_W-1:0]   rem_r  [STEPS-1];
  logic [STEPS-1:0]   root_r [STEPS];

  // Squares, then their sum.
  always_ff @(posedge clk) begin
    if (en) begin
      sqa_r    <= a * a;
      sqb_r    <= b * b;
      rad_r[0] <= RAD_W'(sqa_r) + RAD_W'(sqb_r);
    end
  end

  // One root bit per stage, most significant first.
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int K = STEPS - 1 - j;
    logic [REM_W-1:0] rem_in;
    logic [STEPS-1:0] root_in;
    logic [WRK_W-1:0] rem_sh;
    logic [WRK_W-1:0] trial;
    logic             ge;
    logic [WRK_W-1:0] rem_nxt;
    logic [STEPS-1:0] root_nxt;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end

    always_comb begin
      rem_sh   = {rem_in, rad_r[j][2*K+1], rad_r[j][2*K]};
      trial    = WRK_W'({root_in, 2'b01});
      ge       = rem_sh >= trial;
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_in[STEPS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[j] <= root_nxt;
      end
    end

    if (j < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j]   <= rem_nxt[REM_W-1:0];
          rad_r[j+1] <= rad_r[j];
        end
      end
    end
  end

  assign root = root_r[STEPS-1];

endmodule

[design/ppms_cordic.sv]
// Pipelined vectoring CORDIC giving atan(num/den) in degrees, one rotation per stage.
module ppms_cordic (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ppms_pkg::MAG_W-1:0]  num,
  input  logic [ppms_pkg::MAG_W-1:0]  den,
  output logic [ppms_pkg::K_W-1:0]    angle
);
  import ppms_pkg::*;

  localparam int RND   = ANG_FRAC - FRAC_W;
  localparam int R_W   = Z_W - RND;
  localparam int PAD_W = CV_W - MAG_W - CORDIC_SHIFT;

  logic signed [CV_W-1:0] x_r [CORDIC_STEPS];
  logic signed [CV_W-1:0] y_r [CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_r [CORDIC_STEPS];
  logic [K_W-1:0]         angle_r;

  // Each stage turns the vector toward the x axis by atan(2^-i).
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CV_W-1:0] x_in;
    logic signed [CV_W-1:0] y_in;
    logic signed [Z_W-1:0]  z_in;
    logic signed [CV_W-1:0] xs;
    logic signed [CV_W-1:0] ys;
    logic signed [Z_W-1:0]  step_ang;
    logic signed [CV_W-1:0] x_nxt;
    logic signed [CV_W-1:0] y_nxt;
    logic signed [Z_W-1:0]  z_nxt;

    if (i == 0) begin : g_first
      assign x_in = signed'({{PAD_W{1'b0}}, den, {CORDIC_SHIFT{1'b0}}});
      assign y_in = signed'({{PAD_W{1'b0}}, num, {CORDIC_SHIFT{1'b0}}});
      assign z_in = '0;
    end else begin : g_rest
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
    end

    always_comb begin
      // Shifts round toward zero.
      xs       = x_in[CV_W-1] ? -((-x_in) >>> i) : (x_in >>> i);
      ys       = y_in[CV_W-1] ? -((-y_in) >>> i) : (y_in >>> i);
      step_ang = signed'({{(Z_W-ATAN_W){1'b0}}, ATAN_DEG_Q24[i]});
      if (!y_in[CV_W-1]) begin
        x_nxt = x_in + ys;
        y_nxt = y_in - xs;
        z_nxt = z_in + step_ang;
      end else begin
        x_nxt = x_in - ys;
        y_nxt = y_in + xs;
        z_nxt = z_in - step_ang;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
      end
    end
  end

  // Clamp at zero, round half up to the output fraction and clamp at 90 degrees.
  logic [Z_W-1:0] z_pos;
  logic [Z_W-1:0] z_rnd;
  logic [R_W-1:0] r_full;
  logic [K_W-1:0] angle_nxt;

  always_comb begin
    z_pos  = z_r[CORDIC_STEPS-1][Z_W-1] ? '0 : unsigned'(z_r[CORDIC_STEPS-1]);
    z_rnd  = z_pos + Z_W'(1 << (RND - 1));
    r_full = z_rnd[Z_W-1:RND];
    if (r_full > R_W'(DEG_RIGHT)) begin
      angle_nxt = K_W'(DEG_RIGHT);
    end else begin
      angle_nxt = r_full[K_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign angle = angle_r;

endmodule

[design/point_pair_match_score_top.sv]
// Throughput: one word per cycle while the output is not stalled; the 31-stage
// CORDIC, the 25-stage square root and
// the 25-stage divider are all fully pipelined and move together as one pipeline.
// A stalled output holds the whole pipeline in place; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and clears all registers
// of the configuration port to zero.
`include "point_pair_match_score_top_defines.svh"

// Top level of the point pair match score pipeline.
module point_pair_match_score_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ppms_pkg::COORD_W-1:0] in_a_x,
  input  logic signed [ppms_pkg::COORD_W-1:0] in_a_y,
  input  logic [ppms_pkg::HEAD_W-1:0]         in_a_heading,
  input  logic signed [ppms_pkg::COORD_W-1:0] in_b_x,
  input  logic signed [ppms_pkg::COORD_W-1:0] in_b_y,
  input  logic [ppms_pkg::HEAD_W-1:0]         in_b_heading,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_accepted,
  output logic [ppms_pkg::SCORE_W-1:0]        out_score,
  output logic [ppms_pkg::DIST_W-1:0]         out_distance,
  output logic [ppms_pkg::OPP_W-1:0]          out_heading_opposition,
  output logic [ppms_pkg::AZD_W-1:0]          out_azimuth_difference,
  input  logic                                cfg_we,
  input  logic [ppms_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ppms_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ppms_pkg::*;

  localparam int ISQ_LAT   = 2 + DIST_W;
  localparam int CORD_LAT  = CORDIC_STEPS + 1;
  localparam int DIST_DLY  = CORD_LAT - ISQ_LAT;
  localparam int DIV_STEPS = SCORE_W;
  localparam int DEPTH     = 1 + CORD_LAT + 3 + DIV_STEPS + 1;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = DIST_W + WGT_W;
  localparam int WSUM_W    = WGT_W + 2;
  localparam int VSUM_W    = PROD_W + 2;

  typedef struct packed {
    logic              dx_neg;
    logic              dy_neg;
    logic              dx_zero;
    logic              dy_zero;
    logic [HEAD_W-1:0] ha;
    logic [OPP_W-1:0]  opp;
  } side_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [AZD_W-1:0]  azd;
    logic [OPP_W-1:0]  opp;
  } metric_t;

  typedef struct packed {
    logic    ok;
    metric_t m;
  } tail_t;

  // Relation test of one metric against its threshold.
  function automatic logic rel_holds(input logic [REL_W-1:0] code,
                                     input logic [THR_W-1:0] v,
                                     input logic [THR_W-1:0] t);
    logic res;
    unique case (code)
      REL_GREATER: res = v > t;
      REL_LESS:    res = v < t;
      REL_EQUAL:   res = v == t;
      REL_UNEQUAL: res = v != t;
      default:     res = 1'b1;
    endcase
    return res;
  endfunction

  // Configuration registers.
  logic [REL_REG_W-1:0] rel_r;
  logic [WGT_REG_W-1:0] wgt_r;
  logic [THR_W-1:0]     thr_r [METRICS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_r <= '0;
      wgt_r <= '0;
      for (int m = 0; m < METRICS; m++) begin
        thr_r[m] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RELATION: rel_r    <= cfg_wdata[REL_REG_W-1:0];
        REG_WEIGHTS:  wgt_r    <= cfg_wdata[WGT_REG_W-1:0];
        REG_THR_MAX:  thr_r[0] <= cfg_wdata[THR_W-1:0];
        REG_THR_MIN:  thr_r[1] <= cfg_wdata[THR_W-1:0];
        REG_THR_AZ:   thr_r[2] <= cfg_wdata[THR_W-1:0];
        REG_THR_HEAD: thr_r[3] <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage advances unless the output word is stalled.
  logic             adv;
  logic [DEPTH-1:0] vld_r;

  assign adv      = !vld_r[DEPTH-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  // Stage 1: coordinate differences, their magnitudes and the heading opposition.
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [DIFF_W-1:0]        adx_full;
  logic [DIFF_W-1:0]        ady_full;
  logic [HEAD_W-1:0]        hd;
  logic [HEAD_W-1:0]        opp_full;
  side_t                    side_nxt;
  logic [MAG_W-1:0]         adx_r;
  logic [MAG_W-1:0]         ady_r;
  side_t                    side_r [CORD_LAT+1];

  always_comb begin
    dx       = DIFF_W'(in_b_x) - DIFF_W'(in_a_x);
    dy       = DIFF_W'(in_b_y) - DIFF_W'(in_a_y);
    adx_full = dx[DIFF_W-1] ? unsigned'(-dx) : unsigned'(dx);
    ady_full = dy[DIFF_W-1] ? unsigned'(-dy) : unsigned'(dy);
    hd       = (in_a_heading > in_b_heading) ? (in_a_heading - in_b_heading)
                                             : (in_b_heading - in_a_heading);
    opp_full = (hd >= HEAD_W'(DEG_HALF)) ? (hd - HEAD_W'(DEG_HALF))
                                         : (HEAD_W'(DEG_HALF) - hd);
    side_nxt.dx_neg  = dx[DIFF_W-1];
    side_nxt.dy_neg  = dy[DIFF_W-1];
    side_nxt.dx_zero = dx == '0;
    side_nxt.dy_zero = dy == '0;
    side_nxt.ha      = in_a_heading;
    side_nxt.opp     = (opp_full > HEAD_W'({OPP_W{1'b1}})) ? '1 : opp_full[OPP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      adx_r     <= adx_full[MAG_W-1:0];
      ady_r     <= ady_full[MAG_W-1:0];
      side_r[0] <= side_nxt;
    end
  end

  // Side information follows the CORDIC pipeline.
  for (genvar s = 1; s <= CORD_LAT; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // Distance and arctangent units.
  logic [DIST_W-1:0] root_dist;
  logic [K_W-1:0]    k_ang;

  ppms_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .a    (adx_r),
    .b    (ady_r),
    .root (root_dist)
  );

  ppms_cordic u_cordic (
    .clk   (clk),
    .en    (adv),
    .num   (adx_r),
    .den   (ady_r),
    .angle (k_ang)
  );

  // The distance waits for the arctangent.
  logic [DIST_W-1:0] dist_d_r [DIST_DLY];

  for (genvar d = 0; d < DIST_DLY; d++) begin : g_dist
    if (d == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          dist_d_r[d] <= root_dist;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (adv) begin
          dist_d_r[d] <= dist_d_r[d-1];
        end
      end
    end
  end

  // Stage 34: azimuth from the quadrant and its difference to the heading of A.
  side_t            sq;
  logic [AZD_W-1:0] az;
  logic [AZD_W-1:0] ha_ext;
  metric_t          met_nxt;
  metric_t          met_r;

  always_comb begin
    sq     = side_r[CORD_LAT];
    ha_ext = AZD_W'(sq.ha);
    priority if (sq.dx_zero || sq.dy_zero) begin
      az = '0;
    end else if (!sq.dy_neg && sq.dx_neg) begin
      az = AZD_W'(k_ang);
    end else if (sq.dy_neg && sq.dx_neg) begin
      az = AZD_W'(DEG_HALF) - AZD_W'(k_ang);
    end else if (sq.dy_neg) begin
      az = AZD_W'(DEG_HALF) + AZD_W'(k_ang);
    end else begin
      az = AZD_W'(2 * DEG_HALF) - AZD_W'(k_ang);
    end
    met_nxt.distance = dist_d_r[DIST_DLY-1];
    met_nxt.azd      = (az > ha_ext) ? (az - ha_ext) : (ha_ext - az);
    met_nxt.opp      = sq.opp;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      met_r <= met_nxt;
    end
  end

  // Stage 35: weighted products, weight sum and the relation tests.
  logic [THR_W-1:0]  mval [METRICS];
  logic [PROD_W-1:0] prod_nxt [METRICS];
  logic [WSUM_W-1:0] wsum_nxt;
  logic              ok_nxt;
  logic [PROD_W-1:0] prod_r [METRICS];
  logic [WSUM_W-1:0] wsum_r;
  tail_t             tail_a_r;

  always_comb begin
    mval[0]  = met_r.distance;
    mval[1]  = met_r.distance;
    mval[2]  = THR_W'(met_r.azd);
    mval[3]  = THR_W'(met_r.opp);
    wsum_nxt = '0;
    ok_nxt   = 1'b1;
    for (int m = 0; m < METRICS; m++) begin
      prod_nxt[m] = PROD_W'(wgt_r[WGT_W*m +: WGT_W]) * PROD_W'(mval[m]);
      wsum_nxt    = wsum_nxt + WSUM_W'(wgt_r[WGT_W*m +: WGT_W]);
      if (!rel_holds(rel_r[REL_W*m +: REL_W], mval[m], thr_r[m])) begin
        ok_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r      <= prod_nxt;
      wsum_r      <= wsum_nxt;
      tail_a_r.ok <= ok_nxt;
      tail_a_r.m  <= met_r;
    end
  end

  // Stage 36: sum of products; a zero weight sum rejects the pair.
  logic [VSUM_W-1:0] vsum_r;
  logic [WSUM_W-1:0] wsum_b_r;
  tail_t             tail_b_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      vsum_r      <= (VSUM_W'(prod_r[0]) + VSUM_W'(prod_r[1]))
                   + (VSUM_W'(prod_r[2]) + VSUM_W'(prod_r[3]));
      wsum_b_r    <= wsum_r;
      tail_b_r.ok <= tail_a_r.ok && (wsum_r != '0);
      tail_b_r.m  <= tail_a_r.m;
    end
  end

  // Restoring divider, one quotient bit per stage; the mean never exceeds 25 bits.
  logic [VSUM_W-1:0]  rem_r [DIV_STEPS-1];
  logic [WSUM_W-1:0]  dvs_r [DIV_STEPS-1];
  logic [SCORE_W-1:0] quo_r [DIV_STEPS];
  tail_t              tail_r [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int B = DIV_STEPS - 1 - j;
    logic [VSUM_W-1:0]  rem_in;
    logic [WSUM_W-1:0]  dvs_in;
    logic [SCORE_W-1:0] quo_in;
    tail_t              tail_in;
    logic [VSUM_W-1:0]  dsh;
    logic               ge;
    logic [VSUM_W-1:0]  rem_nxt;
    logic [SCORE_W-1:0] quo_nxt;

    if (j == 0) begin : g_first
      assign rem_in  = vsum_r;
      assign dvs_in  = wsum_b_r;
      assign quo_in  = '0;
      assign tail_in = tail_b_r;
    end else begin : g_rest
      assign rem_in  = rem_r[j-1];
      assign dvs_in  = dvs_r[j-1];
      assign quo_in  = quo_r[j-1];
      assign tail_in = tail_r[j-1];
    end

    always_comb begin
      dsh        = VSUM_W'(dvs_in) << B;
      ge         = rem_in >= dsh;
      rem_nxt    = ge ? (rem_in - dsh) : rem_in;
      quo_nxt    = quo_in;
      quo_nxt[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        quo_r[j]  <= quo_nxt;
        tail_r[j] <= tail_in;
      end
    end

    if (j < DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[j] <= rem_nxt;
          dvs_r[j] <= dvs_in;
        end
      end
    end
  end

  // Output word register.
  logic               acc_r;
  logic [SCORE_W-1:0] score_r;
  metric_t            met_out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r     <= tail_r[DIV_STEPS-1].ok;
      score_r   <= tail_r[DIV_STEPS-1].ok ? quo_r[DIV_STEPS-1] : '0;
      met_out_r <= tail_r[DIV_STEPS-1].m;
    end
  end

  assign out_valid              = vld_r[DEPTH-1];
  assign out_accepted           = acc_r;
  assign out_score              = score_r;
  assign out_distance           = met_out_r.distance;
  assign out_heading_opposition = met_out_r.opp;
  assign out_azimuth_difference = met_out_r.azd;

  // Checks.
  `PPMS_ASSERT(a_reset_empties, clk, !rst_n |=> !out_valid)
  `PPMS_ASSERT_RST(a_reject_zero, clk, rst_n, out_valid && !out_accepted |-> out_score == '0)
  `PPMS_ASSERT_RST(a_mean_bound, clk, rst_n, out_valid && out_accepted |-> (out_score <= out_distance || out_score <= SCORE_W'(out_azimuth_difference) || out_score <= SCORE_W'(out_heading_opposition)))
  `PPMS_ASSERT_RST(a_accept_weights, clk, rst_n, out_valid && out_accepted |-> wgt_r != '0)

endmodule
